### rtl/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants, types and helpers for the multi-slot periodic timer bank.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIME_BITS  = 48;
  localparam int MAX_EVENTS = 8;
  localparam int STAMP_BITS = 16;

  localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
  localparam int EV_MAX  = (MAX_EVENTS < NUM_TIMERS) ? MAX_EVENTS : NUM_TIMERS;
  localparam int EV_W    = (EV_MAX > 1) ? $clog2(EV_MAX) : 1;
  localparam int EVN_W   = $clog2(EV_MAX + 1);

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_INIT  = 3'd1,
    MODE_START = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_STOP  = 3'd4,
    MODE_RESET = 3'd5,
    MODE_QUERY = 3'd6
  } mode_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  target;
    logic [TIME_BITS-1:0]  start;
    logic [31:0]           timeout;
    logic [31:0]           period;
    logic [STAMP_BITS-1:0] stamp;
  } slot_rec_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_rec_t         data;
  } ram_wr_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  target;
    logic [STAMP_BITS-1:0] age;
    logic [SLOT_W-1:0]     id;
  } sort_key_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [2:0] id);
    return SLOT_W'(id);
  endfunction

endpackage
`default_nettype wire

### rtl/msp_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_slot_ram
// Slot record store: one write port, one registered read port. An entry that
// has never been written reads as an all-zero record.
// ----------------------------------------------------------------------------
module msp_slot_ram (
  input  wire                     clk,
  input  wire                     rst_n,
  input  msp_pkg::ram_wr_t        wr,
  input  wire [msp_pkg::SLOT_W-1:0] raddr,
  output msp_pkg::slot_rec_t      rdata
);
  import msp_pkg::*;

  slot_rec_t             mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] written_r;
  slot_rec_t             q_r;
  logic                  q_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      q_vld_r   <= 1'b0;
    end else begin
      if (wr.we) begin
        written_r[wr.addr] <= 1'b1;
      end
      q_vld_r <= written_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule
`default_nettype wire

### rtl/msp_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_sorter
// Insertion sorter: keeps expired slots ordered by target, then recency, then
// slot number, taking one candidate per cycle.
// ----------------------------------------------------------------------------
module msp_sorter (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       clr,
  input  wire                       ins_valid,
  input  msp_pkg::sort_key_t        ins_key,
  output logic [msp_pkg::SLOT_W-1:0] lane_id_o [msp_pkg::NUM_TIMERS],
  output logic [msp_pkg::CNT_W-1:0]  count_o
);
  import msp_pkg::*;

  sort_key_t             lanes_r [NUM_TIMERS];
  logic [CNT_W-1:0]      cnt_r;
  logic [NUM_TIMERS-1:0] keep;
  logic [NUM_TIMERS-1:0] place;
  sort_key_t             shift_src [NUM_TIMERS];

  // Lanes ahead of the new word stay; the first lane that does not stay takes
  // the new word and the rest move down by one.
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      keep[i] = (i < int'(cnt_r)) &&
                ((lanes_r[i].target < ins_key.target) ||
                 ((lanes_r[i].target == ins_key.target) &&
                  (lanes_r[i].age <= ins_key.age)));
    end
    place[0]     = 1'b1;
    shift_src[0] = ins_key;
    for (int i = 1; i < NUM_TIMERS; i++) begin
      place[i]     = keep[i-1];
      shift_src[i] = lanes_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_valid && !clr) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (!keep[i]) begin
          lanes_r[i] <= place[i] ? ins_key : shift_src[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clr) begin
      cnt_r <= '0;
    end else if (ins_valid) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      lane_id_o[i] = lanes_r[i].id;
    end
  end

  assign count_o = cnt_r;

endmodule
`default_nettype wire

### rtl/multi_slot_periodic_timer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Command: handled in S_CMD with busy high; the result word is registered on the outputs.
// Tick: S_SCAN reads every slot record through the single RAM read port, then
// S_SCAN_END and S_PLAN; each expiry gets a read-modify-write re-arm in S_UPD_RD
// and S_UPD_WR, and S_EMIT then sends the expiry words back to back.
// Synchronous reset clears time, stamp counter and flags; every slot record reads
// as zero until first written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_top
// Bank of millisecond timer slots with commands and ordered expiry events.
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire [2:0]  in_mode,
  input  wire [2:0]  in_timer_id,
  input  wire [31:0] in_timeout_ms,
  input  wire [31:0] in_interval_ms,
  input  wire        in_start_now,
  output logic       out_valid,
  output logic       out_kind,
  output logic [2:0] out_slot_id,
  output logic       out_ready_res,
  output logic       out_running,
  output logic       out_last
);
  import msp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_SCAN, S_SCAN_END, S_PLAN, S_UPD_RD, S_UPD_WR, S_EMIT
  } state_t;

  state_t                state_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [STAMP_BITS-1:0] ctr_r;
  logic [NUM_TIMERS-1:0] act_r;
  logic [NUM_TIMERS-1:0] clr_r;
  mode_t                 cmd_mode_r;
  logic [2:0]            cmd_id_r;
  logic [31:0]           cmd_tmo_r;
  logic [31:0]           cmd_ivl_r;
  logic                  cmd_now_r;
  logic [SLOT_W-1:0]     scan_idx_r;
  logic                  rd_vld_r;
  logic [SLOT_W-1:0]     rd_id_r;
  logic [EV_W-1:0]       k_r;
  logic [EVN_W-1:0]      n_r;
  logic [EV_MAX-1:0]     ev_rdy_r;
  logic [EV_MAX-1:0]     ev_run_r;

  logic                  out_valid_r, out_kind_r, out_ready_r, out_running_r, out_last_r;
  logic [2:0]            out_slot_r;

  logic [SLOT_W-1:0]     raddr;
  slot_rec_t             rd_data;
  ram_wr_t               wr;
  logic                  accept;
  logic [SLOT_W-1:0]     cslot;
  logic                  in_range;
  slot_rec_t             nrec;
  logic                  nact, nclr, do_start, take_stamp;
  logic [SLOT_W-1:0]     lane_id [NUM_TIMERS];
  logic [CNT_W-1:0]      sort_cnt;
  logic                  sort_clr, ins_valid;
  sort_key_t             ins_key;
  logic [SLOT_W-1:0]     ev_slot;
  slot_rec_t             upd_rec;
  logic                  upd_rdy, upd_stamp;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cslot    = to_slot(cmd_id_r);
  assign in_range = (int'(cmd_id_r) < NUM_TIMERS);
  assign ev_slot  = lane_id[SLOT_W'(k_r)];

  msp_slot_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign sort_clr  = accept;
  assign ins_valid = rd_vld_r && act_r[rd_id_r] && !clr_r[rd_id_r] &&
                     (rd_data.target <= now_r);
  assign ins_key   = '{target: rd_data.target, age: ctr_r - rd_data.stamp, id: rd_id_r};

  msp_sorter u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (sort_clr),
    .ins_valid (ins_valid),
    .ins_key   (ins_key),
    .lane_id_o (lane_id),
    .count_o   (sort_cnt)
  );

  // Command update of the addressed slot.
  always_comb begin
    nrec       = rd_data;
    nact       = act_r[cslot];
    nclr       = clr_r[cslot];
    do_start   = 1'b0;
    take_stamp = 1'b0;
    unique case (cmd_mode_r)
      MODE_INIT: begin
        nrec.timeout = cmd_tmo_r;
        nrec.period  = cmd_ivl_r;
        nrec.target  = '0;
        nclr         = 1'b1;
        nact         = 1'b0;
        do_start     = cmd_now_r;
      end
      MODE_START: do_start = 1'b1;
      MODE_PAUSE: begin
        if (nact) begin
          nact       = 1'b0;
          nrec.start = (rd_data.target > now_r) ? now_r : rd_data.target;
        end
      end
      MODE_STOP: begin
        nact        = 1'b0;
        nclr        = 1'b1;
        nrec.target = '0;
      end
      MODE_RESET: begin
        nrec.start  = now_r;
        nrec.target = now_r + TIME_BITS'(nrec.timeout);
        nclr        = 1'b0;
      end
      default: ;
    endcase
    if (do_start && !nact) begin
      nact = 1'b1;
      if (nclr) begin
        nrec.target = now_r + TIME_BITS'(nrec.timeout);
        nclr        = 1'b0;
      end else begin
        nrec.target = nrec.target - nrec.start + now_r;
      end
      nrec.start = now_r;
      nrec.stamp = ctr_r;
      take_stamp = 1'b1;
    end
  end

  // Expiry handling: one-shot slots stop, periodic slots move on one period.
  always_comb begin
    upd_rec   = rd_data;
    upd_stamp = 1'b0;
    if (rd_data.period == '0) begin
      upd_rec.target = '0;
      upd_rdy        = 1'b1;
    end else begin
      upd_rec.target = rd_data.target + TIME_BITS'(rd_data.period);
      upd_rec.stamp  = ctr_r;
      upd_stamp      = 1'b1;
      upd_rdy        = (upd_rec.target <= now_r);
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:   raddr = to_slot(in_timer_id);
      S_SCAN:   raddr = scan_idx_r;
      S_UPD_RD: raddr = ev_slot;
      default:  raddr = '0;
    endcase
    wr = '0;
    if (state_r == S_CMD) begin
      wr.we   = in_range;
      wr.addr = cslot;
      wr.data = nrec;
    end else if (state_r == S_UPD_WR) begin
      wr.we   = 1'b1;
      wr.addr = ev_slot;
      wr.data = upd_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode_r <= mode_t'(in_mode);
      cmd_id_r   <= in_timer_id;
      cmd_tmo_r  <= in_timeout_ms;
      cmd_ivl_r  <= in_interval_ms;
      cmd_now_r  <= in_start_now;
    end
    rd_id_r <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      now_r         <= '0;
      ctr_r         <= '0;
      act_r         <= '0;
      clr_r         <= '1;
      scan_idx_r    <= '0;
      rd_vld_r      <= 1'b0;
      k_r           <= '0;
      n_r           <= '0;
      ev_rdy_r      <= '0;
      ev_run_r      <= '0;
      out_valid_r   <= 1'b0;
      out_kind_r    <= 1'b0;
      out_slot_r    <= '0;
      out_ready_r   <= 1'b0;
      out_running_r <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_CMD) || (state_r == S_EMIT);
      rd_vld_r    <= (state_r == S_SCAN);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (mode_t'(in_mode) == MODE_TICK) begin
              now_r      <= now_r + TIME_BITS'(1);
              scan_idx_r <= '0;
              state_r    <= S_SCAN;
            end else begin
              state_r <= S_CMD;
            end
          end
        end
        S_CMD: begin
          if (in_range) begin
            act_r[cslot] <= nact;
            clr_r[cslot] <= nclr;
            if (take_stamp) begin
              ctr_r <= ctr_r + STAMP_BITS'(1);
            end
          end
          out_kind_r    <= 1'b1;
          out_slot_r    <= cmd_id_r;
          out_ready_r   <= in_range ? (nclr || (nrec.target <= now_r)) : 1'b1;
          out_running_r <= in_range ? nact : 1'b0;
          out_last_r    <= 1'b1;
          state_r       <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_idx_r == SLOT_W'(NUM_TIMERS - 1)) begin
            state_r <= S_SCAN_END;
          end else begin
            scan_idx_r <= scan_idx_r + SLOT_W'(1);
          end
        end
        S_SCAN_END: state_r <= S_PLAN;
        S_PLAN: begin
          if (sort_cnt == '0) begin
            state_r <= S_IDLE;
          end else begin
            if (int'(sort_cnt) > EV_MAX) begin
              n_r <= EVN_W'(EV_MAX);
              k_r <= EV_W'(EV_MAX - 1);
            end else begin
              n_r <= EVN_W'(sort_cnt);
              k_r <= EV_W'(sort_cnt - CNT_W'(1));
            end
            state_r <= S_UPD_RD;
          end
        end
        S_UPD_RD: state_r <= S_UPD_WR;
        S_UPD_WR: begin
          // Walk the events backwards so the first event gets the newest stamp.
          if (upd_stamp) begin
            ctr_r <= ctr_r + STAMP_BITS'(1);
          end else begin
            act_r[ev_slot] <= 1'b0;
            clr_r[ev_slot] <= 1'b1;
          end
          ev_rdy_r[k_r] <= upd_rdy;
          ev_run_r[k_r] <= upd_stamp;
          if (k_r == '0) begin
            state_r <= S_EMIT;
          end else begin
            k_r     <= k_r - EV_W'(1);
            state_r <= S_UPD_RD;
          end
        end
        S_EMIT: begin
          out_kind_r    <= 1'b0;
          out_slot_r    <= 3'(ev_slot);
          out_ready_r   <= ev_rdy_r[k_r];
          out_running_r <= ev_run_r[k_r];
          out_last_r    <= (EVN_W'(k_r) + EVN_W'(1) == n_r);
          if (EVN_W'(k_r) + EVN_W'(1) == n_r) begin
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + EV_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_slot_id   = out_slot_r;
  assign out_ready_res = out_ready_r;
  assign out_running   = out_running_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

### rtl/msp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msp_chk
// Port-level checks for the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module msp_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire [2:0] in_mode,
  input wire       out_valid,
  input wire       out_kind,
  input wire       out_last
);
  import msp_pkg::*;

  // A command answer is always the only word of its command.
  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("command answer without last");

  // Every command that is taken is answered by a command word marked last.
  a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode != MODE_TICK) |-> ##2 (out_valid && out_kind && out_last))
    else $error("command answer missing");

  // Expiry words of one tick come back to back until the last one.
  a_evt_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind && !out_last |=> out_valid && !out_kind)
    else $error("expiry burst broken");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a word was taken");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

endmodule

bind multi_slot_periodic_timer_top msp_chk u_msp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_kind  (out_kind),
  .out_last  (out_last)
);
`default_nettype wire

### tb/multi_slot_periodic_timer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_top_tb
// Drives timer commands and ticks into the timer bank, keeps its own model of
// every slot and compares each expiry and acknowledge word in order.
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer_top_tb;
  import msp_pkg::*;

  localparam int NSLOT = 8;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic       kind;
    logic [2:0] slot;
    logic       rdy;
    logic       run;
    logic       last;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_mode = MODE_QUERY;
  logic [2:0]  in_timer_id = '0;
  logic [31:0] in_timeout_ms = '0;
  logic [31:0] in_interval_ms = '0;
  logic        in_start_now = 1'b0;
  wire         busy, out_valid, out_kind, out_ready_res, out_running, out_last;
  wire [2:0]   out_slot_id;

  multi_slot_periodic_timer_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_timer_id(in_timer_id), .in_timeout_ms(in_timeout_ms),
    .in_interval_ms(in_interval_ms), .in_start_now(in_start_now),
    .out_valid(out_valid), .out_kind(out_kind), .out_slot_id(out_slot_id),
    .out_ready_res(out_ready_res), .out_running(out_running), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Model state of the timer bank.
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] tgt [NSLOT];
  logic [TIME_BITS-1:0] t_begin [NSLOT];
  logic [31:0]          tmo_len [NSLOT];
  logic [31:0]          per_len [NSLOT];
  logic                 act [NSLOT];
  logic                 clr [NSLOT];
  logic [15:0]          stamp [NSLOT];
  logic [15:0]          stamp_cnt;

  timer_word_t expected_words[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  n_items = 0;
  int  n_expiries = 0;

  function automatic logic slot_ready(int s);
    return clr[s] || tgt[s] <= now_ms;
  endfunction

  function automatic void give_stamp(int s);
    stamp[s] = stamp_cnt;
    stamp_cnt = stamp_cnt + 16'd1;
  endfunction

  function automatic void arm_fresh(int s);
    t_begin[s] = now_ms;
    tgt[s] = now_ms + TIME_BITS'(tmo_len[s]);
    clr[s] = 1'b0;
  endfunction

  function automatic void start_slot(int s);
    if (act[s]) return;
    act[s] = 1'b1;
    if (clr[s]) arm_fresh(s);
    else begin
      tgt[s] = tgt[s] - t_begin[s] + now_ms;
      t_begin[s] = now_ms;
    end
    give_stamp(s);
  endfunction

  function automatic void bank_reset();
    now_ms = '0;
    stamp_cnt = '0;
    for (int s = 0; s < NSLOT; s++) begin
      tgt[s] = '0; t_begin[s] = '0; tmo_len[s] = '0; per_len[s] = '0;
      act[s] = 1'b0; clr[s] = 1'b1; stamp[s] = '0;
    end
  endfunction

  // Works out the words one accepted item causes and queues them.
  function automatic void predict_timer_words(logic [2:0] mode, logic [2:0] id,
                                              logic [31:0] tmo, logic [31:0] ivl,
                                              logic now_start);
    bit taken [NSLOT];
    int order [NSLOT];
    int n, best;
    logic [15:0] ds, db;
    timer_word_t w;
    n = 0;
    if (mode == MODE_TICK) begin
      now_ms = now_ms + TIME_BITS'(1);
      for (int s = 0; s < NSLOT; s++) taken[s] = 0;
      while (n < MAX_EVENTS) begin
        best = -1;
        for (int s = 0; s < NSLOT; s++) begin
          if (!act[s] || clr[s] || taken[s] || tgt[s] > now_ms) continue;
          if (best < 0 || tgt[s] < tgt[best]) best = s;
          else if (tgt[s] == tgt[best]) begin
            ds = stamp_cnt - stamp[s];
            db = stamp_cnt - stamp[best];
            if (ds < db) best = s;
          end
        end
        if (best < 0) break;
        taken[best] = 1;
        order[n++] = best;
      end
      for (int k = 0; k < n; k++)
        if (per_len[order[k]] == 0) begin
          act[order[k]] = 1'b0; clr[order[k]] = 1'b1; tgt[order[k]] = '0;
        end
      for (int k = n - 1; k >= 0; k--)
        if (per_len[order[k]] != 0) begin
          tgt[order[k]] = tgt[order[k]] + TIME_BITS'(per_len[order[k]]);
          give_stamp(order[k]);
        end
      for (int k = 0; k < n; k++) begin
        w.kind = 1'b0; w.slot = 3'(order[k]); w.rdy = slot_ready(order[k]);
        w.run = act[order[k]]; w.last = (k == n - 1);
        expected_words.push_back(w);
      end
      n_expiries += n;
      return;
    end
    case (mode)
      MODE_INIT: begin
        tmo_len[id] = tmo; per_len[id] = ivl; tgt[id] = '0;
        clr[id] = 1'b1; act[id] = 1'b0;
        if (now_start) start_slot(id);
      end
      MODE_START: start_slot(id);
      MODE_PAUSE: if (act[id]) begin
        act[id] = 1'b0;
        t_begin[id] = (tgt[id] > now_ms) ? now_ms : tgt[id];
      end
      MODE_STOP: begin
        act[id] = 1'b0; clr[id] = 1'b1; tgt[id] = '0;
      end
      MODE_RESET: arm_fresh(id);
      default: ;
    endcase
    w.kind = 1'b1; w.slot = id; w.rdy = slot_ready(id); w.run = act[id]; w.last = 1'b1;
    expected_words.push_back(w);
  endfunction

  // Sends one item after a random gap; the prediction is made at acceptance.
  // A rising edge always passes after the previous word was taken, so start is
  // never driven twice in one time step.
  task automatic send_item(logic [2:0] mode, logic [2:0] id, logic [31:0] tmo,
                           logic [31:0] ivl, logic now_start);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    repeat (gap + 1) @(posedge clk);
    start <= 1'b1;
    in_mode <= mode; in_timer_id <= id; in_timeout_ms <= tmo;
    in_interval_ms <= ivl; in_start_now <= now_start;
    // Busy is settled at the falling edge; low there means the next rising
    // edge takes the word.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_timer_words(mode, id, tmo, ivl, now_start);
    n_items++;
    start <= 1'b0;
  endtask

  task automatic tick_n(int n);
    for (int i = 0; i < n; i++)
      send_item(MODE_TICK, 3'($urandom), $urandom, $urandom, 1'($urandom));
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Word checker: compares every strobed word with the oldest expectation.
  always @(posedge clk) begin
    timer_word_t got, exp_w;
    if (rst_n && out_valid) begin
      got = {out_kind, out_slot_id, out_ready_res, out_running, out_last};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %b", got);
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected kind %0d slot %0d rdy %0d run %0d last %0d,",
                     exp_w.kind, exp_w.slot, exp_w.rdy, exp_w.run, exp_w.last,
                     " got %0d %0d %0d %0d %0d",
                     got.kind, got.slot, got.rdy, got.run, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_commands();
    send_item(MODE_QUERY, 3'd0, '0, '0, 1'b0);
    send_item(MODE_START, 3'd1, '0, '0, 1'b0);              // zero timeout
    send_item(MODE_INIT, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_INIT, 3'd2, 32'd3, 32'd0, 1'b1);
    send_item(MODE_INIT, 3'd3, 32'd3, 32'd2, 1'b1);
    send_item(MODE_PAUSE, 3'd7, '0, '0, 1'b0);
    send_item(MODE_PAUSE, 3'd4, '0, '0, 1'b0);             // pause when idle
    send_item(3'd7, 3'd3, '0, '0, 1'b0);                    // unused mode
    tick_n(2);
    send_item(MODE_START, 3'd7, '0, '0, 1'b0);              // resume
    send_item(MODE_START, 3'd3, '0, '0, 1'b0);              // start while running
    tick_n(3);
    send_item(MODE_RESET, 3'd5, '0, '0, 1'b0);
    send_item(MODE_STOP, 3'd3, '0, '0, 1'b0);
    send_item(MODE_STOP, 3'd7, '0, '0, 1'b0);
    drain();
  endtask

  // All eight slots expire on one tick: ties by recency.
  task automatic test_crowded_tick();
    for (int s = 0; s < NSLOT; s++)
      send_item(MODE_INIT, 3'(s), 32'd2, s[0] ? 32'd1 : 32'd0, 1'b1);
    tick_n(5);
    drain();
  endtask

  task automatic test_random();
    logic [2:0] m;
    logic [31:0] tmo, ivl;
    for (int i = 0; i < 280; i++) begin
      m = ($urandom_range(0, 1) == 0) ? MODE_TICK : 3'($urandom_range(1, 7));
      case ($urandom_range(0, 7))
        0: tmo = $urandom;
        1: tmo = 32'hFFFF_FFFF;
        default: tmo = $urandom_range(0, 6);
      endcase
      case ($urandom_range(0, 7))
        0: ivl = $urandom;
        1, 2: ivl = '0;
        default: ivl = $urandom_range(1, 4);
      endcase
      send_item(m, 3'($urandom), tmo, ivl, 1'($urandom));
      if (i == 140) drain();
    end
  endtask

  initial begin
    bank_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_crowded_tick();
    test_random();
    drain();
    $display("Covered %0d items with %0d expiry words checked.", n_items, n_expiries);
    if (mismatches == 0 && expected_words.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
